// ===== hw/rtl/kclc_pkg.sv =====
// Shared types and constants for the keypad code lock controller.
// Used by kclc_cfg, kclc_core and keypad_code_lock_controller_top; no dependencies.
package kclc_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_KEY       = 2'd0;
  localparam logic [1:0] OP_CHANGE    = 2'd1;
  localparam logic [1:0] OP_UNLOCK    = 2'd2;
  localparam logic [1:0] OP_ALARM_OFF = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_IGNORED  = 4'd0;
  localparam logic [3:0] ST_DIGIT    = 4'd1;
  localparam logic [3:0] ST_CORRECT  = 4'd2;
  localparam logic [3:0] ST_WRONG    = 4'd3;
  localparam logic [3:0] ST_LOCKOUT  = 4'd4;
  localparam logic [3:0] ST_NEWDIGIT = 4'd5;
  localparam logic [3:0] ST_CODESET  = 4'd6;
  localparam logic [3:0] ST_UNLOCK   = 4'd7;
  localparam logic [3:0] ST_ALARMCLR = 4'd8;

  // Configuration register indexes.
  localparam logic [3:0] REG_ATTEMPT_LIMIT = 4'd0;
  localparam logic [3:0] REG_UNLOCK_ANGLE  = 4'd1;

  // Register reset values and servo mapping constants.
  localparam int unsigned LIMIT_RESET  = 3;
  localparam int unsigned ANGLE_RESET  = 45;
  localparam int unsigned ANGLE_MAX    = 180;
  localparam int unsigned SERVO_OFFSET = 25;
  localparam int unsigned SERVO_RESET  = SERVO_OFFSET + (ANGLE_RESET * 11) / 20;

  // Default code digit for position i is ASCII '1' + (i mod 4).
  localparam logic [7:0] CODE_BASE_CHAR = 8'h31;

  // Settings seen by the core.
  typedef struct packed {
    logic [3:0] attempt_limit;
    logic [6:0] servo_value;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0] status;
    logic       alarm_on;
    logic       access_granted;
    logic [3:0] failed_attempts;
    logic [6:0] servo_compare;
    logic       servo_update;
  } result_t;

endpackage

// ===== hw/rtl/kclc_cfg.sv =====
// Configuration registers of the keypad code lock and the servo compare value.
// Depends on kclc_pkg.
module kclc_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [3:0]           cfg_index,
  input  logic [9:0]           cfg_data,
  output kclc_pkg::cfg_t       cfg
);

  logic [3:0]        attempt_limit;
  logic [6:0]        servo_value;
  logic [6:0]        servo_value_next;
  logic [7:0]        clamped;
  logic [10:0]       scaled;
  logic [16:0]       quot_prod;

  // Clamp the written angle to 0..180, then 25 + floor(a*11/20). The divide by 20
  // is a shift by two followed by a divide by five done as multiply by 205 and
  // shift by ten, which is exact for all dividends below 1024.
  always_comb begin
    if (cfg_data[9]) begin
      clamped = 8'd0;
    end else if (cfg_data[8:0] > 9'(kclc_pkg::ANGLE_MAX)) begin
      clamped = 8'(kclc_pkg::ANGLE_MAX);
    end else begin
      clamped = cfg_data[7:0];
    end
    scaled           = 11'(clamped) * 11'd11;
    quot_prod        = 17'(scaled[10:2]) * 17'd205;
    servo_value_next = 7'(kclc_pkg::SERVO_OFFSET) + quot_prod[16:10];
  end

  // Register writes. The angle register is kept as its servo compare value, so
  // both registers take effect at the edge of the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= 4'(kclc_pkg::LIMIT_RESET);
      servo_value   <= 7'(kclc_pkg::SERVO_RESET);
    end else if (cfg_write) begin
      if (cfg_index == kclc_pkg::REG_ATTEMPT_LIMIT) begin
        attempt_limit <= cfg_data[3:0];
      end
      if (cfg_index == kclc_pkg::REG_UNLOCK_ANGLE) begin
        servo_value <= servo_value_next;
      end
    end
  end

  assign cfg.attempt_limit = attempt_limit;
  assign cfg.servo_value   = servo_value;

endmodule

// ===== hw/rtl/kclc_core.sv =====
// Lock state and the per-item decision logic of the keypad code lock.
// Depends on kclc_pkg.
module kclc_core #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          opcode,
  input  logic [7:0]          key_code,
  input  kclc_pkg::cfg_t      cfg,
  output kclc_pkg::result_t   result
);

  localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH - 1);

  logic [7:0]       stored_code [CODE_LENGTH];
  logic [7:0]       entry_keys  [CODE_LENGTH];
  logic [POS_W-1:0] entry_position;
  logic [POS_W-1:0] entry_position_next;
  logic [POS_W-1:0] new_code_position;
  logic [POS_W-1:0] new_code_position_next;
  logic [3:0]       failure_count;
  logic [3:0]       failure_count_next;
  logic [3:0]       failure_inc;
  logic             verified_flag;
  logic             verified_flag_next;
  logic             alarm_flag;
  logic             alarm_flag_next;
  logic             change_mode;
  logic             change_mode_next;
  logic             code_write;
  logic             entry_write;
  logic             code_match;
  logic             entry_open;
  logic [3:0]       status;

  // Full-entry compare: earlier keys come from the entry buffer, the last
  // key straight from the current item.
  always_comb begin
    code_match = (key_code == stored_code[CODE_LENGTH-1]);
    for (int i = 0; i < CODE_LENGTH - 1; i++) begin
      if (entry_keys[i] != stored_code[i]) begin
        code_match = 1'b0;
      end
    end
  end

  assign entry_open  = !verified_flag && (failure_count < cfg.attempt_limit);
  assign failure_inc = failure_count + 4'd1;

  // Decision for one item.
  always_comb begin
    entry_position_next    = entry_position;
    new_code_position_next = new_code_position;
    failure_count_next     = failure_count;
    verified_flag_next     = verified_flag;
    alarm_flag_next        = alarm_flag;
    change_mode_next       = change_mode;
    code_write             = 1'b0;
    entry_write            = 1'b0;
    status                 = kclc_pkg::ST_IGNORED;
    case (opcode)
      kclc_pkg::OP_KEY: begin
        if (change_mode) begin
          code_write = 1'b1;
          if (new_code_position == LAST_POS) begin
            new_code_position_next = '0;
            change_mode_next       = 1'b0;
            status                 = kclc_pkg::ST_CODESET;
          end else begin
            new_code_position_next = new_code_position + 1'b1;
            status                 = kclc_pkg::ST_NEWDIGIT;
          end
        end else if (entry_open) begin
          entry_write = 1'b1;
          if (entry_position == LAST_POS) begin
            entry_position_next = '0;
            if (code_match) begin
              verified_flag_next = 1'b1;
              failure_count_next = 4'd0;
              status             = kclc_pkg::ST_CORRECT;
            end else begin
              failure_count_next = failure_inc;
              if (failure_inc >= cfg.attempt_limit) begin
                alarm_flag_next = 1'b1;
                status          = kclc_pkg::ST_LOCKOUT;
              end else begin
                status = kclc_pkg::ST_WRONG;
              end
            end
          end else begin
            entry_position_next = entry_position + 1'b1;
            status              = kclc_pkg::ST_DIGIT;
          end
        end
      end
      kclc_pkg::OP_CHANGE: begin
        if (verified_flag) begin
          change_mode_next       = 1'b1;
          new_code_position_next = '0;
        end
      end
      kclc_pkg::OP_UNLOCK: begin
        if (verified_flag) begin
          status = kclc_pkg::ST_UNLOCK;
        end
      end
      kclc_pkg::OP_ALARM_OFF: begin
        alarm_flag_next    = 1'b0;
        failure_count_next = 4'd0;
        status             = kclc_pkg::ST_ALARMCLR;
      end
      default: begin
        status = kclc_pkg::ST_IGNORED;
      end
    endcase
  end

  // Control state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_position    <= '0;
      new_code_position <= '0;
      failure_count     <= 4'd0;
      verified_flag     <= 1'b0;
      alarm_flag        <= 1'b0;
      change_mode       <= 1'b0;
    end else if (step) begin
      entry_position    <= entry_position_next;
      new_code_position <= new_code_position_next;
      failure_count     <= failure_count_next;
      verified_flag     <= verified_flag_next;
      alarm_flag        <= alarm_flag_next;
      change_mode       <= change_mode_next;
    end
  end

  // Stored code: default digits at reset, overwritten key by key in change mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_code[i] <= kclc_pkg::CODE_BASE_CHAR + 8'(i % 4);
      end
    end else if (step && code_write) begin
      stored_code[new_code_position] <= key_code;
    end
  end

  // Entry buffer holds the keys typed so far in this attempt.
  always_ff @(posedge clk) begin
    if (step && entry_write) begin
      entry_keys[entry_position] <= key_code;
    end
  end

  assign result.status          = status;
  assign result.alarm_on        = alarm_flag_next;
  assign result.access_granted  = verified_flag_next;
  assign result.failed_attempts = failure_count_next;
  assign result.servo_update    = (status == kclc_pkg::ST_UNLOCK);
  assign result.servo_compare   = (status == kclc_pkg::ST_UNLOCK) ? cfg.servo_value : 7'd0;

endmodule

// ===== hw/rtl/keypad_code_lock_controller_top.sv =====
// Each item passes the input register and then the result register; throughput is one
// transaction per cycle unless the result is stalled. The decision logic in kclc_core
// updates the lock state as each item moves from the input to the result register.
// Reset (rst, synchronous, active high) clears the lock state, restores the default
// code "1234", attempt limit 3 and unlock angle 45, and empties both registers.
// Depends on kclc_pkg, kclc_cfg and kclc_core.
module keypad_code_lock_controller_top #(
  parameter int CODE_LENGTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status,
  output logic       alarm_on,
  output logic       access_granted,
  output logic [3:0] failed_attempts,
  output logic [6:0] servo_compare,
  output logic       servo_update
);

  kclc_pkg::cfg_t    cfg;
  kclc_pkg::result_t core_result;
  kclc_pkg::result_t result;
  logic              in_full;
  logic [1:0]        in_opcode;
  logic [7:0]        in_key;
  logic              out_full;
  logic              advance;

  kclc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kclc_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .opcode   (in_opcode),
    .key_code (in_key),
    .cfg      (cfg),
    .result   (core_result)
  );

  // An item moves on when the result register is empty or being drained.
  assign advance  = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_opcode <= opcode;
      in_key    <= key_code;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  assign out_valid       = out_full;
  assign status          = result.status;
  assign alarm_on        = result.alarm_on;
  assign access_granted  = result.access_granted;
  assign failed_attempts = result.failed_attempts;
  assign servo_compare   = result.servo_compare;
  assign servo_update    = result.servo_update;

  // A servo update only comes with an unlock while access is granted.
  a_servo_unlock: assert property (@(posedge clk) disable iff (rst)
    out_valid && servo_update |-> status == kclc_pkg::ST_UNLOCK && access_granted)
    else $error("servo update without a granted unlock");

  // A lockout always raises the alarm.
  a_lockout_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == kclc_pkg::ST_LOCKOUT |-> alarm_on)
    else $error("lockout reported without alarm");

  // A correct entry grants access and clears the failure count.
  a_correct_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == kclc_pkg::ST_CORRECT |-> access_granted && failed_attempts == 4'd0)
    else $error("correct entry left failures or no access");

  // The input side stalls only while an item waits behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_full && out_stall)
    else $error("input stalled without a blocked result");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled result changed");

endmodule

// ===== tb/sv/kclc_tb_pkg.sv =====
// Scoreboard for the keypad code lock controller testbench: a cycle-free copy of the
// lock state that predicts each result transaction and checks the ones the block returns.
// Depends on kclc_pkg for the operation and status codes and the result layout.
package kclc_tb_pkg;
  import kclc_pkg::*;

  localparam int CODE_LEN = 4;

  // Servo mapping: compare = offset + angle * 11 / 20 (fixed-point form of 0.55).
  localparam int SERVO_NUM = 11;
  localparam int SERVO_DEN = 20;

  class lock_scoreboard;
    // Lock state as the block should hold it.
    logic [CODE_LEN-1:0][7:0] stored_code;
    logic [CODE_LEN-1:0][7:0] entry_keys;
    int unsigned              entry_pos;
    int unsigned              newcode_pos;
    logic [3:0]               fail_cnt;
    bit                       verified;
    bit                       alarm;
    bit                       changing;

    // Register copies.
    logic [3:0]               attempt_limit;
    logic signed [9:0]        unlock_angle;

    result_t                  pending_lock_results[$];
    int unsigned              error_count;

    function new();
      for (int i = 0; i < CODE_LEN; i++) begin
        stored_code[i] = CODE_BASE_CHAR + 8'(i % 4);
        entry_keys[i]  = 8'h00;
      end
      entry_pos     = 0;
      newcode_pos   = 0;
      fail_cnt      = '0;
      verified      = 1'b0;
      alarm         = 1'b0;
      changing      = 1'b0;
      attempt_limit = 4'(LIMIT_RESET);
      unlock_angle  = 10'(ANGLE_RESET);
      error_count   = 0;
    endfunction

    function void write_register(logic [3:0] idx, logic [9:0] value);
      case (idx)
        REG_ATTEMPT_LIMIT: attempt_limit = value[3:0];
        REG_UNLOCK_ANGLE:  unlock_angle  = value;
        default: ;
      endcase
    endfunction

    // Clamp the signed angle to 0..180 and map it onto the servo compare range.
    function logic [6:0] servo_for_angle();
      int a;
      a = unlock_angle;
      if (a < 0) begin
        a = 0;
      end else if (a > int'(ANGLE_MAX)) begin
        a = int'(ANGLE_MAX);
      end
      return 7'(int'(SERVO_OFFSET) + (a * SERVO_NUM) / SERVO_DEN);
    endfunction

    // Advance the lock state by one accepted input transaction and queue its result.
    function void note_key_event(logic [1:0] op, logic [7:0] key);
      result_t r;
      r = '0;
      r.status = ST_IGNORED;
      case (op)
        OP_KEY: begin
          // A change in progress takes the key ahead of code entry.
          if (changing) begin
            stored_code[newcode_pos] = key;
            if (newcode_pos == CODE_LEN - 1) begin
              newcode_pos = 0;
              changing    = 1'b0;
              r.status    = ST_CODESET;
            end else begin
              newcode_pos++;
              r.status = ST_NEWDIGIT;
            end
          end else if (!verified && fail_cnt < attempt_limit) begin
            entry_keys[entry_pos] = key;
            if (entry_pos == CODE_LEN - 1) begin
              entry_pos = 0;
              if (entry_keys == stored_code) begin
                verified = 1'b1;
                fail_cnt = '0;
                r.status = ST_CORRECT;
              end else begin
                fail_cnt = fail_cnt + 4'd1;
                if (fail_cnt >= attempt_limit) begin
                  alarm    = 1'b1;
                  r.status = ST_LOCKOUT;
                end else begin
                  r.status = ST_WRONG;
                end
              end
            end else begin
              entry_pos++;
              r.status = ST_DIGIT;
            end
          end
        end
        OP_CHANGE: begin
          // Accepted silently; while verified, the counter restarts on every press.
          if (verified) begin
            changing    = 1'b1;
            newcode_pos = 0;
          end
        end
        OP_UNLOCK: begin
          if (verified) begin
            r.servo_compare = servo_for_angle();
            r.servo_update  = 1'b1;
            r.status        = ST_UNLOCK;
          end
        end
        default: begin
          alarm    = 1'b0;
          fail_cnt = '0;
          r.status = ST_ALARMCLR;
        end
      endcase
      r.alarm_on        = alarm;
      r.access_granted  = verified;
      r.failed_attempts = fail_cnt;
      pending_lock_results.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_lock_results.size();
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        error_count++;
      end
    endfunction

    // Compare one returned transaction against the oldest prediction.
    function void check_lock_result(result_t got);
      result_t want;
      if (pending_lock_results.size() == 0) begin
        $error("result transaction with no prediction waiting: status %0d", got.status);
        error_count++;
        return;
      end
      want = pending_lock_results.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("alarm_on", 8'(want.alarm_on), 8'(got.alarm_on));
      compare_field("access_granted", 8'(want.access_granted), 8'(got.access_granted));
      compare_field("failed_attempts", 8'(want.failed_attempts), 8'(got.failed_attempts));
      compare_field("servo_compare", 8'(want.servo_compare), 8'(got.servo_compare));
      compare_field("servo_update", 8'(want.servo_update), 8'(got.servo_update));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for keypad_code_lock_controller_top: drives key and button
// transactions with random pacing and back-pressure, checks results via kclc_tb_pkg.
// Depends on kclc_pkg, kclc_tb_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kclc_pkg::*;
  import kclc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = OP_KEY;
  logic [7:0] key_code = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] status;
  logic       alarm_on;
  logic       access_granted;
  logic [3:0] failed_attempts;
  logic [6:0] servo_compare;
  logic       servo_update;

  lock_scoreboard sb;
  int unsigned    cycle_count = 0;
  int unsigned    burst_left = 0;
  bit             no_idle = 1'b0;
  bit             hold_off_req = 1'b0;

  keypad_code_lock_controller_top #(
    .CODE_LENGTH(CODE_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .key_code(key_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .alarm_on(alarm_on),
    .access_granted(access_granted),
    .failed_attempts(failed_attempts),
    .servo_compare(servo_compare),
    .servo_update(servo_update)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check accepted transactions and stall on a pattern of its own,
  // with a long hold-off whenever the sender asks for one.
  initial begin : receiver
    result_t     got;
    int unsigned mode_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.status          = status;
        got.alarm_on        = alarm_on;
        got.access_granted  = access_granted;
        got.failed_attempts = failed_attempts;
        got.servo_compare   = servo_compare;
        got.servo_update    = servo_update;
        sb.check_lock_result(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = 80;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 150);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one input transaction and wait until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [7:0] key);
    in_valid <= 1'b1;
    opcode   <= op;
    key_code <= key;
    do @(posedge clk); while (in_stall);
    sb.note_key_event(op, key);
  endtask

  // Send, then possibly close the burst with a random gap.
  task automatic offer(input logic [1:0] op, input logic [7:0] key);
    int unsigned gap;
    send_item(op, key);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write both registers back to back; only called with the block idle.
  task automatic apply_settings(input logic [3:0] limit, input logic [9:0] angle);
    cfg_write <= 1'b1;
    cfg_index <= REG_ATTEMPT_LIMIT;
    cfg_data  <= {6'd0, limit};
    @(posedge clk);
    sb.write_register(REG_ATTEMPT_LIMIT, {6'd0, limit});
    cfg_index <= REG_UNLOCK_ANGLE;
    cfg_data  <= angle;
    @(posedge clk);
    sb.write_register(REG_UNLOCK_ANGLE, angle);
    cfg_write <= 1'b0;
  endtask

  // A full entry that is close to the default code but always wrong in one key.
  task automatic send_wrong_entry();
    logic [7:0]  keys [CODE_LEN];
    int unsigned bad;
    for (int i = 0; i < CODE_LEN; i++) begin
      keys[i] = $urandom_range(0, 1) ? CODE_BASE_CHAR + 8'(i) : 8'($urandom);
    end
    bad = $urandom_range(0, CODE_LEN - 1);
    keys[bad] = (CODE_BASE_CHAR + 8'(bad)) ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < CODE_LEN; i++) begin
      offer(OP_KEY, keys[i]);
    end
  endtask

  // Random traffic while the lock is not yet verified: mostly full wrong entries,
  // plus alarm clears, stray keys and buttons that are ignored at this point.
  task automatic locked_phase(input logic [3:0] limit, input logic [9:0] angle,
                              input int unsigned n_items, input bit squeeze);
    int unsigned sent;
    int unsigned pick;
    drain();
    apply_settings(limit, angle);
    no_idle = ($urandom_range(0, 3) == 0);
    if (squeeze) begin
      hold_off_req = 1'b1;
    end
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_wrong_entry();
        sent += CODE_LEN;
      end else if (pick < 80) begin
        offer(OP_ALARM_OFF, 8'($urandom));
        sent++;
      end else if (pick < 92) begin
        offer(OP_KEY, 8'($urandom));
        sent++;
      end else begin
        offer($urandom_range(0, 1) ? OP_CHANGE : OP_UNLOCK, 8'($urandom));
        sent++;
      end
    end
  endtask

  // Random traffic once verified: code changes (some cut short and restarted),
  // unlocks, alarm clears and keys that are ignored outside a change.
  task automatic unlocked_phase(input logic [3:0] limit, input logic [9:0] angle,
                                input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned n_keys;
    drain();
    apply_settings(limit, angle);
    no_idle = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        offer(OP_CHANGE, 8'($urandom));
        n_keys = $urandom_range(1, 6);
        for (int i = 0; i < n_keys; i++) begin
          offer(OP_KEY, 8'($urandom));
        end
        sent += n_keys + 1;
      end else if (pick < 70) begin
        offer(OP_UNLOCK, 8'($urandom));
        sent++;
      end else if (pick < 82) begin
        offer(OP_ALARM_OFF, 8'($urandom));
        sent++;
      end else begin
        offer(OP_KEY, 8'($urandom));
        sent++;
      end
    end
  endtask

  // Stimulus. Verification is only cleared by reset, so all entry behavior is
  // exercised first and the verified behavior afterwards.
  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Buttons before verification are ignored.
    send_item(OP_CHANGE, 8'h00);
    send_item(OP_UNLOCK, 8'hFF);
    // Wrong entries, including the key extremes, up to the default lockout.
    send_item(OP_KEY, "1");
    send_item(OP_KEY, "2");
    send_item(OP_KEY, "3");
    send_item(OP_KEY, "5");
    send_item(OP_KEY, 8'h00);
    send_item(OP_KEY, 8'hFF);
    send_item(OP_KEY, "3");
    send_item(OP_KEY, "4");
    repeat (CODE_LEN) send_item(OP_KEY, "9");
    // Keys are ignored while locked out, until the alarm is cleared.
    send_item(OP_KEY, "1");
    send_item(OP_ALARM_OFF, 8'h5A);

    locked_phase(4'd1, 10'h200, 150, 1'b0);
    locked_phase(4'd15, 10'h1FF, 150, 1'b1);
    // A zero limit locks entry out from the start.
    locked_phase(4'd0, 10'd180, 40, 1'b0);
    locked_phase(4'($urandom_range(1, 15)), 10'($urandom), 150, 1'b0);
    locked_phase(4'd3, 10'd45, 130, 1'b0);

    // Line up on an entry boundary, then verify with an alarm clear in the
    // middle of the entry, which keeps the keys typed so far.
    drain();
    apply_settings(4'd15, 10'd45);
    send_item(OP_ALARM_OFF, 8'h00);
    while (sb.entry_pos != 0) begin
      send_item(OP_KEY, 8'h00);
    end
    send_item(OP_KEY, "1");
    send_item(OP_KEY, "2");
    send_item(OP_ALARM_OFF, 8'hFF);
    send_item(OP_KEY, "3");
    send_item(OP_KEY, "4");
    send_item(OP_KEY, "7");
    send_item(OP_UNLOCK, 8'h00);
    // A change restarted halfway, then completed with new key extremes.
    send_item(OP_CHANGE, 8'h00);
    send_item(OP_KEY, 8'hFF);
    send_item(OP_KEY, 8'h00);
    send_item(OP_CHANGE, 8'h00);
    send_item(OP_KEY, 8'h80);
    send_item(OP_KEY, 8'h7F);
    send_item(OP_KEY, 8'h00);
    send_item(OP_KEY, 8'hFF);
    send_item(OP_UNLOCK, 8'hA5);

    unlocked_phase(4'd1, 10'd0, 80);
    unlocked_phase(4'd15, 10'd180, 80);
    unlocked_phase(4'($urandom_range(0, 15)), 10'd181, 80);
    unlocked_phase(4'($urandom_range(0, 15)), 10'h3FF, 80);
    unlocked_phase(4'($urandom_range(0, 15)), 10'h1FF, 80);
    unlocked_phase(4'($urandom_range(0, 15)), 10'h200, 80);
    unlocked_phase(4'($urandom_range(0, 15)), 10'($urandom), 80);

    // Let the pipeline settle so any stray result is seen.
    drain();
    repeat (8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
